// ===== design/aes_pkg.sv =====
package aes_pkg;

   localparam int unsigned NUM_ROUNDS = 10;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   // Register indexes on the configuration port.
   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   // Forward S-box.
   function automatic byte_type sbox(input byte_type a);
      byte_type r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r=8'h00;
      endcase
      return r;
   endfunction

   // Round constant for round key 1..10.
   function automatic byte_type rcon(input logic [3:0] rnd);
      byte_type r;
      case (rnd)
         4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
         4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
         4'd9: r = 8'h1b; 4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xtime(input byte_type a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Next round key. Byte 0 of the block sits at bits 127:120.
   function automatic block_type next_key(input block_type k, input logic [3:0] rnd);
      logic [31:0] t;
      block_type n;
      t = {sbox(k[23:16]) ^ rcon(rnd), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
      n[127:96] = k[127:96] ^ t;
      n[95:64]  = k[95:64] ^ n[127:96];
      n[63:32]  = k[63:32] ^ n[95:64];
      n[31:0]   = k[31:0] ^ n[63:32];
      return n;
   endfunction

   // SubBytes and ShiftRows: row r of column c takes row r of column c+r.
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = sbox(s[127 - 8*(4*((c + r) % 4) + r) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic block_type mix(input block_type s);
      block_type t;
      byte_type a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32*c -: 8];
         a1 = s[119 - 32*c -: 8];
         a2 = s[111 - 32*c -: 8];
         a3 = s[103 - 32*c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

endpackage

// ===== design/aes_key_sched.sv =====
// Expands the key into eleven registered round keys; recomputed after each key write.
module aes_key_sched (
   input  logic                       clock,
   input  aes_pkg::block_type         key,
   output aes_pkg::block_type [10:0]  sched_keys
);
   import aes_pkg::*;

   block_type [10:0] rk_ff;
   block_type [10:0] rk_in;

   // One expansion step per register; round key i is computed from the registered round key i-1.
   always_comb begin
      rk_in[0] = key;
      for (int i = 1; i <= 10; i++) begin
         rk_in[i] = next_key(rk_ff[i-1], 4'(i));
      end
   end

   always_ff @(posedge clock) begin
      rk_ff <= rk_in;
   end

   assign sched_keys = rk_ff;
endmodule

// ===== design/aes_round.sv =====
// One round stage with its own valid bit; it holds while advance is low.
module aes_round #(
   parameter bit LAST = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  aes_pkg::block_type  in_state,
   input  aes_pkg::block_type  stage_key,
   output logic                out_valid,
   output aes_pkg::block_type  out_state
);
   import aes_pkg::*;

   block_type state_ff, state_in;
   logic valid_ff;

   // SubBytes, ShiftRows, MixColumns unless last, then AddRoundKey.
   always_comb begin
      if (LAST) begin
         state_in = sub_shift(in_state) ^ stage_key;
      end else begin
         state_in = mix(sub_shift(in_state)) ^ stage_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
endmodule

// ===== design/aes128_block_encrypt.sv =====
// AES-128 encryption, one 128-bit block per cycle while the output is not stalled. The
// pipeline has eleven register stages (initial AddRoundKey, then one per round); a block
// appears on rsp_ after passing all of them, and a block can enter every cycle unless
// the output stalls. The round keys come from a registered schedule that trails the key
// registers by one stage per round, so the first block under a new key may transfer once
// the first schedule register holds it; each round key reaches its stage ahead of it.
module aes128_block_encrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plaintext_high,
   input  logic [63:0] req_plaintext_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_ciphertext_high,
   output logic [63:0] rsp_ciphertext_low
);
   import aes_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   block_type [10:0] sched_keys;
   logic [NUM_ROUNDS:0] valid;
   block_type [NUM_ROUNDS:0] state;
   logic advance;
   logic valid0_ff;
   block_type state0_ff;

   // Key register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_write_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   aes_key_sched u_sched (
      .clock      (clock),
      .key        ({key_high_ff, key_low_ff}),
      .sched_keys (sched_keys)
   );

   // Whole pipeline moves unless the output holds a result not taken.
   assign advance   = !valid[NUM_ROUNDS] || rsp_ready;
   assign req_ready = advance;

   // Initial AddRoundKey stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state0_ff <= {req_plaintext_high, req_plaintext_low} ^ sched_keys[0];
      end
   end

   assign valid[0] = valid0_ff;
   assign state[0] = state0_ff;

   // Ten round stages.
   for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
      aes_round #(.LAST(r == NUM_ROUNDS)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid[r-1]),
         .in_state  (state[r-1]),
         .stage_key (sched_keys[r]),
         .out_valid (valid[r]),
         .out_state (state[r])
      );
   end

   assign rsp_valid           = valid[NUM_ROUNDS];
   assign rsp_ciphertext_high = state[NUM_ROUNDS][127:64];
   assign rsp_ciphertext_low  = state[NUM_ROUNDS][63:0];

   // A stalled result stays valid and its high half holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ciphertext_high))
      else $error("result changed under stall");
   // Input is refused only when the output stalls.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without stall");
   // A transfer in reaches stage 0 on the next edge.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid0_ff)
      else $error("accepted block lost");
endmodule

// ===== dv/testbench.sv =====
module testbench;
   import aes_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic [63:0] csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_plaintext_high;
   logic [63:0] req_plaintext_low;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_ciphertext_high;
   logic [63:0] rsp_ciphertext_low;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned LONG_HOLD      = 300;

   // One directed vector; check_ct marks rows whose ciphertext is typed in.
   typedef struct {
      logic [127:0] key;
      logic [127:0] pt;
      logic [127:0] ct;
      bit           check_ct;
   } vector_type;

   logic [7:0]   sub_lut [256];
   logic [127:0] cur_key;
   logic [127:0] ciphertext_queue [$];
   int unsigned  mismatches;
   int unsigned  blocks_sent;
   int unsigned  blocks_checked;
   int unsigned  keys_loaded;
   int unsigned  idle_cycles;
   int unsigned  hold_left;
   bit           sender_steady;
   bit           receiver_steady;
   bit           long_hold_done;

   aes128_block_encrypt uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_plaintext_high(req_plaintext_high), .req_plaintext_low(req_plaintext_low),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_ciphertext_high(rsp_ciphertext_high), .rsp_ciphertext_low(rsp_ciphertext_low)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Multiplication in GF(2^8) modulo the AES polynomial.
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   // The substitution table is derived from the field inverse and the affine map.
   task automatic build_sub_lut();
      logic [7:0] inv;
      for (int a = 0; a < 256; a++) begin
         inv = 8'h00;
         for (int b = 1; b < 256; b++) begin
            if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
         end
         sub_lut[a] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                      ^ rotl8(inv, 4) ^ 8'h63;
      end
   endtask

   // Byte i of a block sits at bits 127-8i; state row i%4, column i/4.
   function automatic logic [127:0] aes_encrypt_block(input logic [127:0] key,
                                                       input logic [127:0] pt);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   w [4];
      logic [7:0]   rc;
      logic [7:0]   a0, a1, a2, a3, all;
      logic [127:0] rk;
      logic [127:0] res;
      rk = key;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) s[i] = pt[127 - 8*i -: 8] ^ rk[127 - 8*i -: 8];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         // Next round key from the last word: rotate, substitute, add the round constant.
         w[0] = sub_lut[rk[23:16]] ^ rc;
         w[1] = sub_lut[rk[15:8]];
         w[2] = sub_lut[rk[7:0]];
         w[3] = sub_lut[rk[31:24]];
         rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         for (int j = 0; j < 4; j++) begin
            for (int b = 0; b < 4; b++) begin
               w[b] = w[b] ^ rk[127 - 32*j - 8*b -: 8];
               rk[127 - 32*j - 8*b -: 8] = w[b];
            end
         end
         // Substitution combined with the row rotation.
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[4*c + r] = sub_lut[s[4*((c + r) % 4) + r]];
         // Column mixing in all but the last round.
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c + 1]; a2 = t[4*c + 2]; a3 = t[4*c + 3];
            if (rnd < 10) begin
               all = a0 ^ a1 ^ a2 ^ a3;
               a0 = t[4*c] ^ all ^ gf_mul(t[4*c] ^ t[4*c + 1], 8'h02);
               a1 = t[4*c + 1] ^ all ^ gf_mul(t[4*c + 1] ^ t[4*c + 2], 8'h02);
               a2 = t[4*c + 2] ^ all ^ gf_mul(t[4*c + 2] ^ t[4*c + 3], 8'h02);
               a3 = t[4*c + 3] ^ all ^ gf_mul(t[4*c + 3] ^ t[4*c], 8'h02);
            end
            s[4*c] = a0; s[4*c + 1] = a1; s[4*c + 2] = a2; s[4*c + 3] = a3;
         end
         for (int i = 0; i < 16; i++) s[i] ^= rk[127 - 8*i -: 8];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s at block %0d: got %h, want %h",
               field, blocks_checked, got, want);
      mismatches++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Wait until every ciphertext is back and the pipeline has emptied.
   task automatic drain();
      while (ciphertext_queue.size() != 0) @(posedge clock);
      repeat (14) @(posedge clock);
   endtask

   // Load a new key while idle, then give the key schedule time to settle.
   task automatic load_key(input logic [127:0] key);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_KEY_HIGH;
      csr_write_data   <= key[127:64];
      @(posedge clock);
      csr_index        <= CSR_KEY_LOW;
      csr_write_data   <= key[63:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_key = key;
      keys_loaded++;
      repeat (14) @(posedge clock);
   endtask

   // Offer one block and hold it until the transfer; the expectation is queued there.
   task automatic send_block(input logic [127:0] pt);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_plaintext_high <= pt[127:64];
      req_plaintext_low  <= pt[63:0];
      do @(posedge clock); while (!req_ready);
      ciphertext_queue.push_back(aes_encrypt_block(cur_key, pt));
      blocks_sent++;
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
   endtask

   // Result side: check each transfer against the oldest expectation, then draw a stall unless steady.
   always @(posedge clock) begin
      logic [127:0] want;
      int unsigned  gap;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ciphertext_queue.size() == 0) begin
               $display("unexpected ciphertext %h%h", rsp_ciphertext_high, rsp_ciphertext_low);
               mismatches++;
            end else begin
               want = ciphertext_queue.pop_front();
               if (rsp_ciphertext_high !== want[127:64])
                  report_mismatch("ciphertext_high", rsp_ciphertext_high, want[127:64]);
               if (rsp_ciphertext_low !== want[63:0])
                  report_mismatch("ciphertext_low", rsp_ciphertext_low, want[63:0]);
            end
            blocks_checked++;
            if (!long_hold_done && blocks_checked == 500) begin
               long_hold_done = 1'b1;
               hold_left <= LONG_HOLD;
               rsp_ready <= 1'b0;
            end else if (receiver_steady) begin
               rsp_ready <= 1'b1;
            end else begin
               // A draw of zero keeps ready high; otherwise ready goes low and hold_left counts the stall down.
               gap = $urandom_range(10);
               if (gap == 0) begin
                  rsp_ready <= 1'b1;
               end else begin
                  hold_left <= gap - 1;
                  rsp_ready <= 1'b0;
               end
            end
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      vector_type   vectors [$];
      logic [127:0] phase_keys [6];
      logic [127:0] pt;
      logic [127:0] want;
      int unsigned  ones;

      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_KEY_HIGH;
      csr_write_data     = '0;
      req_valid          = 1'b0;
      req_plaintext_high = '0;
      req_plaintext_low  = '0;
      rsp_ready          = 1'b0;
      mismatches = 0; blocks_sent = 0; blocks_checked = 0; keys_loaded = 0;
      idle_cycles = 0; hold_left = 0;
      sender_steady = 1'b0; receiver_steady = 1'b0; long_hold_done = 1'b0;
      cur_key = '0;
      build_sub_lut();

      // Known-answer vectors first, then extremes and bit patterns.
      vectors.push_back('{128'h0, 128'h0, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1});
      vectors.push_back('{128'h000102030405060708090a0b0c0d0e0f,
                          128'h00112233445566778899aabbccddeeff,
                          128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1});
      vectors.push_back('{128'h2b7e151628aed2a6abf7158809cf4f3c,
                          128'h3243f6a8885a308d313198a2e0370734,
                          128'h3925841d02dc09fbdc118597196a0b32, 1'b1});
      vectors.push_back('{128'h0, {128{1'b1}}, 128'h0, 1'b0});
      vectors.push_back('{128'h0, {64{2'b01}}, 128'h0, 1'b0});
      vectors.push_back('{{128{1'b1}}, 128'h0, 128'h0, 1'b0});
      vectors.push_back('{{128{1'b1}}, {128{1'b1}}, 128'h0, 1'b0});
      vectors.push_back('{{128{1'b1}}, {64{2'b10}}, 128'h0, 1'b0});
      vectors.push_back('{{64{2'b10}}, 128'h1, 128'h0, 1'b0});
      vectors.push_back('{{64{2'b10}}, {1'b1, 127'h0}, 128'h0, 1'b0});
      vectors.push_back('{{64{2'b01}}, 128'h0000000000000001_8000000000000000, 128'h0, 1'b0});
      vectors.push_back('{{64{2'b01}}, 128'hffffffffffffffff_0000000000000000, 128'h0, 1'b0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First block runs on the reset key, which is all zero.
      send_block(128'h0);
      end_burst();

      // Directed table; typed-in ciphertexts replace the predictor's entry.
      foreach (vectors[i]) begin
         if (vectors[i].key !== cur_key) begin
            end_burst();
            load_key(vectors[i].key);
         end
         send_block(vectors[i].pt);
         if (vectors[i].check_ct) begin
            want = ciphertext_queue.pop_back();
            if (want !== vectors[i].ct) begin
               $display("predictor disagrees with the known answer for vector %0d", i);
               mismatches++;
            end
            ciphertext_queue.push_back(vectors[i].ct);
         end
      end
      end_burst();

      // Random blocks under several keys; one phase runs with no idling at all.
      phase_keys[0] = {rand64(), rand64()};
      phase_keys[1] = {128{1'b1}};
      phase_keys[2] = {rand64(), rand64()};
      phase_keys[3] = 128'h0;
      phase_keys[4] = {rand64(), rand64()};
      phase_keys[5] = {rand64(), rand64()};
      for (int p = 0; p < 6; p++) begin
         end_burst();
         load_key(phase_keys[p]);
         sender_steady   = (p == 2);
         receiver_steady = (p == 2);
         for (int n = 0; n < 230; n++) begin
            pt = {rand64(), rand64()};
            // Now and then a sparse or dense block to reach the extremes.
            ones = $urandom_range(15);
            if (ones == 0) pt = 128'h0;
            else if (ones == 1) pt = {128{1'b1}};
            else if (ones == 2) pt = 128'h1 << $urandom_range(127);
            send_block(pt);
            // Midway through phase 4 the sender waits for every ciphertext to return.
            if (p == 4 && n == 100) begin
               end_burst();
               while (ciphertext_queue.size() != 0) @(posedge clock);
            end
         end
      end
      end_burst();
      sender_steady = 1'b0;
      receiver_steady = 1'b0;

      drain();
      $display("Sent %0d blocks, checked %0d ciphertexts under %0d key loads,",
               blocks_sent, blocks_checked, keys_loaded);
      $display("with random stalls on both sides and one long output hold.");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/aes_pkg.sv
design/aes_key_sched.sv
design/aes_round.sv
design/aes128_block_encrypt.sv
dv/testbench.sv
